@@ sv/tcw_pkg.sv @@
`default_nettype none
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF = 25;

    localparam int KIND_W = 2;
    localparam int CODE_W = 8;
    localparam int COLOR_W = 8;
    localparam int INDEX_W = 11;
    localparam int WORD_W = 16;
    localparam int OUT_COL_W = 7;
    localparam int OUT_ROW_W = 5;
    localparam int IN_DATA_W = 32;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CODE_W-1:0] CODE_LF = 8'd10;
    localparam logic [CODE_W-1:0] CODE_CR = 8'd13;

    localparam logic [WORD_W-1:0] CLEAR_FILL_RESET = 16'h0720;
    localparam logic [WORD_W-1:0] SCROLL_FILL_RESET = 16'h0F20;

    localparam logic [CFG_INDEX_W-1:0] REG_CLEAR_FILL = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_FILL = 1'd1;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUT   = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_READ  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_FILL,
        ST_CLEAR
    } t_state;

    typedef struct packed {
        logic [WORD_W-1:0]    cell_word;
        logic                 scrolled;
        logic [OUT_ROW_W-1:0] cursor_row;
        logic [OUT_COL_W-1:0] cursor_col;
    } t_result;

endpackage
`default_nettype wire

@@ sv/tcw_cell_mem.sv @@
`default_nettype none
module tcw_cell_mem #(
    parameter int DEPTH = 2000,
    parameter int AW = 11,
    parameter int DW = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

@@ sv/tcw_seq.sv @@
`default_nettype none
module tcw_seq #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS = tcw_pkg::ROWS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [tcw_pkg::KIND_W-1:0]   i_kind,
    input  wire logic [tcw_pkg::CODE_W-1:0]   i_char_code,
    input  wire logic [tcw_pkg::COLOR_W-1:0]  i_color,
    input  wire logic [tcw_pkg::INDEX_W-1:0]  i_cell_index,
    input  wire logic [tcw_pkg::WORD_W-1:0]   i_clear_word,
    input  wire logic [tcw_pkg::WORD_W-1:0]   i_scroll_word,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output tcw_pkg::t_result                  o_result
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);
    localparam int AW = $clog2(CELL_COUNT);
    localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
    localparam logic [AW-1:0] ADDR_LAST = AW'(CELL_COUNT - 1);
    localparam logic [AW-1:0] ROW_STEP = AW'(COLUMNS);
    localparam logic [AW-1:0] BOTTOM_BASE = AW'(CELL_COUNT - COLUMNS);

    tcw_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [AW-1:0] r_base, n_base;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [AW-1:0] r_waddr, n_waddr;
    logic r_wpend, n_wpend;
    logic r_in_range, n_in_range;
    logic r_out_valid, n_out_valid;
    tcw_pkg::t_result r_out, n_out;

    logic mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [tcw_pkg::WORD_W-1:0] mem_wdata, mem_rdata;

    logic out_free, accept, is_lf, is_cr, col_last, row_last, adv_row;
    logic [31:0] idx_ext;

    tcw_cell_mem #(
        .DEPTH(CELL_COUNT),
        .AW(AW),
        .DW(tcw_pkg::WORD_W)
    ) u_mem (
        .i_clk(i_clk),
        .i_we(mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_re(mem_re),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    assign out_free = !r_out_valid || i_ready;
    assign accept = (r_state == tcw_pkg::ST_IDLE) && out_free && i_valid;
    assign is_lf = i_char_code == tcw_pkg::CODE_LF;
    assign is_cr = i_char_code == tcw_pkg::CODE_CR;
    assign col_last = r_col == COL_LAST;
    assign row_last = r_row == ROW_LAST;
    assign adv_row = is_lf || (!is_cr && col_last);
    assign idx_ext = 32'(i_cell_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcw_pkg::ST_INIT;
            r_col <= '0;
            r_row <= '0;
            r_base <= '0;
            r_ptr <= '0;
            r_wpend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col <= n_col;
            r_row <= n_row;
            r_base <= n_base;
            r_ptr <= n_ptr;
            r_wpend <= n_wpend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_waddr <= n_waddr;
        r_in_range <= n_in_range;
        r_out <= n_out;
    end

    always_comb begin
        n_state = r_state;
        n_col = r_col;
        n_row = r_row;
        n_base = r_base;
        n_ptr = r_ptr;
        n_waddr = r_waddr;
        n_wpend = r_wpend;
        n_in_range = r_in_range;
        n_out_valid = r_out_valid && !i_ready;
        n_out = r_out;
        mem_we = 1'b0;
        mem_waddr = r_ptr;
        mem_wdata = i_scroll_word;
        mem_re = 1'b0;
        mem_raddr = r_ptr;
        o_ready = 1'b0;

        unique case (r_state)
            tcw_pkg::ST_INIT, tcw_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wdata = (r_state == tcw_pkg::ST_INIT) ?
                            tcw_pkg::CLEAR_FILL_RESET : i_clear_word;
                if (r_ptr == ADDR_LAST) begin
                    n_ptr = '0;
                    n_state = tcw_pkg::ST_IDLE;
                    if (r_state == tcw_pkg::ST_CLEAR) begin
                        n_out_valid = 1'b1;
                        n_out = '0;
                    end
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            tcw_pkg::ST_IDLE: begin
                o_ready = out_free;
                if (accept) begin
                    unique case (tcw_pkg::t_kind'(i_kind))
                        tcw_pkg::KIND_PUT: begin
                            if (!is_lf && !is_cr) begin
                                mem_we = 1'b1;
                                mem_waddr = r_base + AW'(r_col);
                                mem_wdata = {i_color, i_char_code};
                            end
                            n_col = (is_lf || is_cr || col_last) ? '0 : r_col + CW'(1);
                            if (adv_row && row_last) begin
                                n_ptr = ROW_STEP;
                                n_wpend = 1'b0;
                                n_state = tcw_pkg::ST_COPY;
                            end else begin
                                if (adv_row) begin
                                    n_row = r_row + RW'(1);
                                    n_base = r_base + ROW_STEP;
                                end
                                n_out_valid = 1'b1;
                                n_out.cursor_col = tcw_pkg::OUT_COL_W'(n_col);
                                n_out.cursor_row = tcw_pkg::OUT_ROW_W'(n_row);
                                n_out.scrolled = 1'b0;
                                n_out.cell_word = '0;
                            end
                        end
                        tcw_pkg::KIND_CLEAR: begin
                            n_col = '0;
                            n_row = '0;
                            n_base = '0;
                            n_ptr = '0;
                            n_state = tcw_pkg::ST_CLEAR;
                        end
                        tcw_pkg::KIND_READ: begin
                            mem_re = 1'b1;
                            mem_raddr = idx_ext[AW-1:0];
                            n_in_range = idx_ext < 32'(CELL_COUNT);
                            n_state = tcw_pkg::ST_READ;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_out.cursor_col = tcw_pkg::OUT_COL_W'(r_col);
                            n_out.cursor_row = tcw_pkg::OUT_ROW_W'(r_row);
                            n_out.scrolled = 1'b0;
                            n_out.cell_word = '0;
                        end
                    endcase
                end
            end
            tcw_pkg::ST_READ: begin
                n_out_valid = 1'b1;
                n_out.cursor_col = tcw_pkg::OUT_COL_W'(r_col);
                n_out.cursor_row = tcw_pkg::OUT_ROW_W'(r_row);
                n_out.scrolled = 1'b0;
                n_out.cell_word = r_in_range ? mem_rdata : '0;
                n_state = tcw_pkg::ST_IDLE;
            end
            tcw_pkg::ST_COPY: begin
                mem_re = 1'b1;
                mem_raddr = r_ptr;
                mem_we = r_wpend;
                mem_waddr = r_waddr;
                mem_wdata = mem_rdata;
                n_waddr = r_ptr - ROW_STEP;
                n_wpend = 1'b1;
                if (r_ptr == ADDR_LAST) begin
                    n_ptr = BOTTOM_BASE;
                    n_state = tcw_pkg::ST_FILL;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            tcw_pkg::ST_FILL: begin
                mem_we = 1'b1;
                if (r_wpend) begin
                    mem_waddr = r_waddr;
                    mem_wdata = mem_rdata;
                    n_wpend = 1'b0;
                end else if (r_ptr == ADDR_LAST) begin
                    n_ptr = '0;
                    n_state = tcw_pkg::ST_IDLE;
                    n_out_valid = 1'b1;
                    n_out.cursor_col = tcw_pkg::OUT_COL_W'(r_col);
                    n_out.cursor_row = tcw_pkg::OUT_ROW_W'(r_row);
                    n_out.scrolled = 1'b1;
                    n_out.cell_word = '0;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            default: begin
                n_state = tcw_pkg::ST_INIT;
            end
        endcase
    end

    assign o_valid = r_out_valid;
    assign o_result = r_out;

endmodule
`default_nettype wire

@@ sv/text_console_writer.sv @@
// Text console writer over a ROWS x COLUMNS store of 16-bit character cells.
// Input transactions arrive on the s_axis channel; tuser carries the kind
// (put character, clear screen, read one cell) and tdata the character, color
// and cell index. Every input transaction yields exactly one m_axis
// transaction with the cursor after the step, a scroll flag and, for a read,
// the cell word. The two fill words are set through the plain write port.
// A put character without scroll is accepted and its result is
// registered at the same edge. A read goes through the memory read and the
// READ state before its result is registered. A scroll moves every cell below
// the top row up by one row, one cell per cycle through the single write port,
// then fills the bottom row. A clear writes every cell once.
// After reset the block runs a clearing pass over all ROWS*COLUMNS cells (2000 by
// default) that fills the memory with 0x0720; no transaction is accepted then,
// while configuration writes are taken as ever.
// The block works on one transaction at a time. The result sits in an output
// register; a new input is accepted when that register is empty or is being
// taken, so a stalled receiver holds off the input side.
`default_nettype none
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS = tcw_pkg::ROWS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // char_code [7:0], color [15:8], cell_index [26:16], zero fill above.
    input  wire logic [tcw_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    // kind [1:0].
    input  wire logic [tcw_pkg::KIND_W-1:0]         i_s_axis_tuser,
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // cursor_col [6:0], cursor_row [11:7], scrolled [12], cell_word [28:13].
    output logic [tcw_pkg::OUT_DATA_W-1:0]          o_m_axis_tdata,
    input  wire logic                               i_cfg_we,
    input  wire logic [tcw_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [tcw_pkg::WORD_W-1:0]         i_cfg_data
);

    logic [tcw_pkg::WORD_W-1:0] r_clear_word;
    logic [tcw_pkg::WORD_W-1:0] r_scroll_word;
    tcw_pkg::t_result result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear_word <= tcw_pkg::CLEAR_FILL_RESET;
            r_scroll_word <= tcw_pkg::SCROLL_FILL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tcw_pkg::REG_CLEAR_FILL: r_clear_word <= i_cfg_data;
                tcw_pkg::REG_SCROLL_FILL: r_scroll_word <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tcw_seq #(
        .COLUMNS(COLUMNS),
        .ROWS(ROWS)
    ) u_seq (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_s_axis_tvalid),
        .o_ready(o_s_axis_tready),
        .i_kind(i_s_axis_tuser),
        .i_char_code(i_s_axis_tdata[7:0]),
        .i_color(i_s_axis_tdata[15:8]),
        .i_cell_index(i_s_axis_tdata[26:16]),
        .i_clear_word(r_clear_word),
        .i_scroll_word(r_scroll_word),
        .o_valid(o_m_axis_tvalid),
        .i_ready(i_m_axis_tready),
        .o_result(result)
    );

    assign o_m_axis_tdata = tcw_pkg::OUT_DATA_W'(result);

endmodule
`default_nettype wire

@@ test/text_console_writer_tb.sv @@
`timescale 1ns / 1ps
module text_console_writer_tb;

    localparam int COLUMNS = tcw_pkg::COLUMNS_DEF;
    localparam int ROWS = tcw_pkg::ROWS_DEF;
    localparam int CELLS = COLUMNS * ROWS;
    localparam int INDEX_W = tcw_pkg::INDEX_W;
    localparam int KIND_W = tcw_pkg::KIND_W;
    localparam int CODE_W = tcw_pkg::CODE_W;
    localparam int COLOR_W = tcw_pkg::COLOR_W;
    localparam int WORD_W = tcw_pkg::WORD_W;
    localparam int CFG_INDEX_W = tcw_pkg::CFG_INDEX_W;
    localparam int MAX_INDEX = (1 << INDEX_W) - 1;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int PHASES = 5;
    localparam int PHASE_ITEMS = 350;
    localparam int TOTAL_ITEMS = 25 + PHASES * PHASE_ITEMS;
    localparam int LONG_HOLD_AT = 600;
    localparam int LONG_HOLD_CYCLES = 500;
    localparam int LIMIT_CYCLES =
        4 * (3 * CELLS + LONG_HOLD_CYCLES + TOTAL_ITEMS * (CELLS + 60));

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [CODE_W-1:0]  code;
        logic [COLOR_W-1:0] color;
        logic [INDEX_W-1:0] cell_index;
    } t_console_cmd;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_s_axis_tvalid = 1'b0;
    logic                             o_s_axis_tready;
    logic [tcw_pkg::IN_DATA_W-1:0]    i_s_axis_tdata = '0;
    logic [KIND_W-1:0]                i_s_axis_tuser = '0;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready = 1'b0;
    logic [tcw_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata;
    logic                             i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]           i_cfg_index = '0;
    logic [WORD_W-1:0]                i_cfg_data = '0;

    text_console_writer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    logic [WORD_W-1:0] screen_model [CELLS];
    logic [WORD_W-1:0] clear_word;
    logic [WORD_W-1:0] scroll_word;
    int                cur_col;
    int                cur_row;

    t_console_cmd      command_queue [$];
    tcw_pkg::t_result  due_reports [$];
    int                mismatch_count = 0;
    int                cycle_count = 0;

    function automatic tcw_pkg::t_result console_step(t_console_cmd cmd);
        tcw_pkg::t_result res;
        int               at;
        int               i;
        res = '0;
        case (cmd.kind)
            tcw_pkg::KIND_PUT: begin
                if (cmd.code == tcw_pkg::CODE_LF) begin
                    cur_col = 0;
                    cur_row++;
                end else if (cmd.code == tcw_pkg::CODE_CR) begin
                    cur_col = 0;
                end else begin
                    at = cur_row * COLUMNS + cur_col;
                    if (at < CELLS) screen_model[at] = {cmd.color, cmd.code};
                    cur_col++;
                end
                if (cur_col >= COLUMNS) begin
                    cur_col = 0;
                    cur_row++;
                end
                if (cur_row >= ROWS) begin
                    for (i = 0; i < CELLS - COLUMNS; i++) screen_model[i] = screen_model[i + COLUMNS];
                    for (i = CELLS - COLUMNS; i < CELLS; i++) screen_model[i] = scroll_word;
                    cur_row = ROWS - 1;
                    res.scrolled = 1'b1;
                end
            end
            tcw_pkg::KIND_CLEAR: begin
                for (i = 0; i < CELLS; i++) screen_model[i] = clear_word;
                cur_col = 0;
                cur_row = 0;
            end
            tcw_pkg::KIND_READ: begin
                if (cmd.cell_index < CELLS) res.cell_word = screen_model[cmd.cell_index];
            end
            default: begin
            end
        endcase
        res.cursor_col = cur_col[tcw_pkg::OUT_COL_W-1:0];
        res.cursor_row = cur_row[tcw_pkg::OUT_ROW_W-1:0];
        return res;
    endfunction

    function automatic t_console_cmd make_cmd(logic [KIND_W-1:0] kind, logic [CODE_W-1:0] code,
                                              logic [COLOR_W-1:0] color,
                                              logic [INDEX_W-1:0] cell_index);
        t_console_cmd cmd;
        cmd.kind = kind;
        cmd.code = code;
        cmd.color = color;
        cmd.cell_index = cell_index;
        return cmd;
    endfunction

    function automatic t_console_cmd random_cmd();
        t_console_cmd cmd;
        int           pick;
        int           sel;
        cmd = make_cmd(tcw_pkg::KIND_PUT, CODE_W'($urandom_range(0, 255)),
                       COLOR_W'($urandom_range(0, 255)),
                       INDEX_W'($urandom_range(0, MAX_INDEX)));
        pick = $urandom_range(0, 999);
        if (pick < 700) begin
            sel = $urandom_range(0, 99);
            if (sel < 25) cmd.code = tcw_pkg::CODE_LF;
            else if (sel < 30) cmd.code = tcw_pkg::CODE_CR;
        end else if (pick < 960) begin
            cmd.kind = tcw_pkg::KIND_READ;
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                cmd.cell_index = INDEX_W'($urandom_range(ROWS - 5, ROWS - 1) * COLUMNS
                                          + $urandom_range(0, COLUMNS - 1));
            end else if (sel < 47) begin
                cmd.cell_index = INDEX_W'($urandom_range(CELLS, MAX_INDEX));
            end
        end else if (pick < 964) begin
            cmd.kind = tcw_pkg::KIND_CLEAR;
        end else begin
            cmd.kind = KIND_UNUSED;
        end
        return cmd;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [WORD_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (index == tcw_pkg::REG_CLEAR_FILL) clear_word = value;
        else scroll_word = value;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (command_queue.size() != 0 || due_reports.size() != 0 || i_s_axis_tvalid) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Sender: one command per transaction, with a random gap before each.
    int           gap_left = 0;
    bit           tx_idle_mode = 1'b1;
    t_console_cmd current_cmd;

    always @(posedge i_clk) begin
        logic valid_n;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            valid_n = i_s_axis_tvalid;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                due_reports.push_back(console_step(current_cmd));
                valid_n = 1'b0;
                if ($urandom_range(0, 49) == 0) tx_idle_mode = !tx_idle_mode;
                gap_left = tx_idle_mode ? $urandom_range(0, 19) : 0;
            end
            if (!valid_n) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (command_queue.size() != 0) begin
                    current_cmd = command_queue.pop_front();
                    i_s_axis_tdata <= {5'b0, current_cmd.cell_index, current_cmd.color,
                                       current_cmd.code};
                    i_s_axis_tuser <= current_cmd.kind;
                    valid_n = 1'b1;
                end
            end
            i_s_axis_tvalid <= valid_n;
        end
    end

    // Receiver: random stalls, plus one long hold-off to back up the input side.
    int stall_left = 0;
    int hold_left = 0;
    int reports_seen = 0;
    bit rx_idle_mode = 1'b1;

    always @(posedge i_clk) begin
        tcw_pkg::t_result got;
        tcw_pkg::t_result want;
        logic             ready_n;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = tcw_pkg::t_result'(o_m_axis_tdata[$bits(tcw_pkg::t_result)-1:0]);
                if (due_reports.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none got 0x%0h",
                             $time, o_m_axis_tdata);
                    mismatch_count++;
                end else begin
                    want = due_reports.pop_front();
                    check_field("cursor_col", WORD_W'(want.cursor_col), WORD_W'(got.cursor_col));
                    check_field("cursor_row", WORD_W'(want.cursor_row), WORD_W'(got.cursor_row));
                    check_field("scrolled", WORD_W'(want.scrolled), WORD_W'(got.scrolled));
                    check_field("cell_word", want.cell_word, got.cell_word);
                end
                reports_seen++;
                if ($urandom_range(0, 49) == 0) rx_idle_mode = !rx_idle_mode;
                stall_left = rx_idle_mode ? $urandom_range(0, 19) : 0;
                if (reports_seen == LONG_HOLD_AT) hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_n = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ready_n = 1'b0;
            end else begin
                ready_n = 1'b1;
            end
            i_m_axis_tready <= ready_n;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("** text_console_writer: FAILED **");
            $finish;
        end
    end

    initial begin
        int i;
        int phase;
        clear_word = tcw_pkg::CLEAR_FILL_RESET;
        scroll_word = tcw_pkg::SCROLL_FILL_RESET;
        for (i = 0; i < CELLS; i++) screen_model[i] = tcw_pkg::CLEAR_FILL_RESET;
        cur_col = 0;
        cur_row = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        command_queue.push_back(make_cmd(tcw_pkg::KIND_READ, 8'h00, 8'h00, 11'd0));
        command_queue.push_back(make_cmd(tcw_pkg::KIND_READ, 8'hFF, 8'hFF,
                                         INDEX_W'(CELLS - 1)));
        command_queue.push_back(make_cmd(tcw_pkg::KIND_READ, 8'h00, 8'h00, INDEX_W'(CELLS)));
        command_queue.push_back(make_cmd(tcw_pkg::KIND_READ, 8'h00, 8'h00,
                                         INDEX_W'(MAX_INDEX)));
        command_queue.push_back(make_cmd(tcw_pkg::KIND_PUT, 8'h00, 8'h00, 11'd0));
        command_queue.push_back(make_cmd(tcw_pkg::KIND_PUT, 8'hFF, 8'hFF,
                                         INDEX_W'(MAX_INDEX)));
        command_queue.push_back(make_cmd(tcw_pkg::KIND_PUT, 8'h41, 8'h1E, 11'd0));
        command_queue.push_back(make_cmd(tcw_pkg::KIND_PUT, tcw_pkg::CODE_CR, 8'hFF, 11'd0));
        command_queue.push_back(make_cmd(tcw_pkg::KIND_PUT, 8'h5A, 8'h70, 11'd0));
        command_queue.push_back(make_cmd(tcw_pkg::KIND_PUT, tcw_pkg::CODE_LF, 8'hAA,
                                         INDEX_W'(MAX_INDEX)));
        command_queue.push_back(make_cmd(tcw_pkg::KIND_PUT, 8'h7E, 8'h81, 11'd0));
        command_queue.push_back(make_cmd(KIND_UNUSED, 8'hFF, 8'hFF, INDEX_W'(MAX_INDEX)));
        command_queue.push_back(make_cmd(tcw_pkg::KIND_READ, 8'h00, 8'h00, 11'd0));
        command_queue.push_back(make_cmd(tcw_pkg::KIND_READ, 8'h00, 8'h00, 11'd1));
        command_queue.push_back(make_cmd(tcw_pkg::KIND_READ, 8'h00, 8'h00, 11'd2));
        command_queue.push_back(make_cmd(tcw_pkg::KIND_READ, 8'h00, 8'h00,
                                         INDEX_W'(COLUMNS)));
        command_queue.push_back(make_cmd(tcw_pkg::KIND_CLEAR, 8'hFF, 8'hFF,
                                         INDEX_W'(MAX_INDEX)));
        command_queue.push_back(make_cmd(tcw_pkg::KIND_READ, 8'h00, 8'h00, 11'd0));
        command_queue.push_back(make_cmd(tcw_pkg::KIND_READ, 8'h00, 8'h00,
                                         INDEX_W'(COLUMNS)));
        command_queue.push_back(make_cmd(tcw_pkg::KIND_READ, 8'h00, 8'h00,
                                         INDEX_W'(CELLS - 1)));
        command_queue.push_back(make_cmd(tcw_pkg::KIND_PUT, tcw_pkg::CODE_LF, 8'h00, 11'd0));
        command_queue.push_back(make_cmd(tcw_pkg::KIND_PUT, 8'h0A + 8'd1, 8'h0F, 11'd0));
        command_queue.push_back(make_cmd(tcw_pkg::KIND_READ, 8'h00, 8'h00,
                                         INDEX_W'(COLUMNS)));

        for (phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            case (phase)
                0: begin
                    write_reg(tcw_pkg::REG_CLEAR_FILL, 16'h0000);
                    write_reg(tcw_pkg::REG_SCROLL_FILL, 16'hFFFF);
                end
                1: begin
                    write_reg(tcw_pkg::REG_CLEAR_FILL, 16'hFFFF);
                    write_reg(tcw_pkg::REG_SCROLL_FILL, 16'h0000);
                end
                default: begin
                    write_reg(tcw_pkg::REG_CLEAR_FILL, WORD_W'($urandom_range(0, 16'hFFFF)));
                    write_reg(tcw_pkg::REG_SCROLL_FILL, WORD_W'($urandom_range(0, 16'hFFFF)));
                end
            endcase
            @(negedge i_clk);
            for (i = 0; i < PHASE_ITEMS; i++) command_queue.push_back(random_cmd());
        end

        wait_idle();
        repeat (CELLS + 100) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("** text_console_writer: PASSED **");
        end else begin
            $display("** text_console_writer: FAILED **");
        end
        $finish;
    end

endmodule
